// ===== hdl/bmi_bit_manipulation_alu_unit_assert.svh =====
// assertion macros for the bit manipulation alu
// no dependencies; taken in by the rtl files that carry assertions
`ifndef BMI_BIT_MANIPULATION_ALU_UNIT_ASSERT_SVH
`define BMI_BIT_MANIPULATION_ALU_UNIT_ASSERT_SVH

`ifndef SYNTH

// clocked implication check, held off while reset is high
`define BMI_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also runs during reset
`define BMI_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BMI_ASSERT_CLK(label, clk, rst, prop, msg)
`define BMI_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== hdl/bmi_pkg.sv =====
// shared types and constants for the bit manipulation alu
// no dependencies
`default_nettype none

package bmi_pkg;

   // operation codes
   typedef enum logic [2:0] {
      FUNC_ANDN   = 3'd0,
      FUNC_BLSR   = 3'd1,
      FUNC_BLSMSK = 3'd2,
      FUNC_BLSI   = 3'd3,
      FUNC_BZHI   = 3'd4,
      FUNC_BEXTR  = 3'd5
   } func_type;

   localparam int unsigned FUNC_W  = 3;
   localparam int unsigned DATA_W  = 64;
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SAFE_FLAGS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PF_CLEARED = 1'd1;

   // operand sizes in bits
   localparam logic [7:0] SIZE_WIDE   = 8'd64;
   localparam logic [7:0] SIZE_NARROW = 8'd32;

   localparam logic [DATA_W-1:0] NARROW_MASK = 64'h0000_0000_FFFF_FFFF;

   typedef struct packed {
      logic safe_undefined_flags;
      logic pf_cleared_mode;
   } cfg_type;

   typedef struct packed {
      logic [DATA_W-1:0] result;
      logic              carry_flag;
      logic              zero_flag;
      logic              sign_flag;
      logic              overflow_flag;
      logic              adjust_flag;
      logic              parity_flag;
      logic              af_pf_written;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hdl/bmi_req_if.sv =====
// request channel of the bit manipulation alu: valid/ready plus operands
// depends on bmi_pkg for widths
`default_nettype none

interface bmi_req_if;
   logic                         valid;
   logic                         ready;
   logic [bmi_pkg::FUNC_W-1:0]   func;
   logic                         wide;
   logic [bmi_pkg::DATA_W-1:0]   src_a;
   logic [bmi_pkg::DATA_W-1:0]   src_b;

   modport source (output valid, func, wide, src_a, src_b, input ready);
   modport sink   (input valid, func, wide, src_a, src_b, output ready);
endinterface

`default_nettype wire

// ===== hdl/bmi_rsp_if.sv =====
// response channel of the bit manipulation alu: valid/ready plus result and flags
// depends on bmi_pkg for widths
`default_nettype none

interface bmi_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [bmi_pkg::DATA_W-1:0]   result;
   logic                         carry_flag;
   logic                         zero_flag;
   logic                         sign_flag;
   logic                         overflow_flag;
   logic                         adjust_flag;
   logic                         parity_flag;
   logic                         af_pf_written;

   modport source (output valid, result, carry_flag, zero_flag, sign_flag, overflow_flag,
                   adjust_flag, parity_flag, af_pf_written, input ready);
   modport sink   (input valid, result, carry_flag, zero_flag, sign_flag, overflow_flag,
                   adjust_flag, parity_flag, af_pf_written, output ready);
endinterface

`default_nettype wire

// ===== hdl/bmi_csr.sv =====
// configuration registers of the bit manipulation alu
// depends on bmi_pkg
`default_nettype none

module bmi_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [bmi_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [bmi_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output bmi_pkg::cfg_type                       cfg
);

   bmi_pkg::cfg_type cfg_ff;
   bmi_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            bmi_pkg::CSR_SAFE_FLAGS: cfg_in.safe_undefined_flags = csr_wdata[0];
            bmi_pkg::CSR_PF_CLEARED: cfg_in.pf_cleared_mode      = csr_wdata[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== hdl/bmi_exec.sv =====
// combinational datapath: one bmi operation with its flags
// depends on bmi_pkg
`default_nettype none

module bmi_exec (
   input  wire logic [bmi_pkg::FUNC_W-1:0]  func,
   input  wire logic                        wide,
   input  wire logic [bmi_pkg::DATA_W-1:0]  src_a,
   input  wire logic [bmi_pkg::DATA_W-1:0]  src_b,
   input  wire bmi_pkg::cfg_type            cfg,
   output bmi_pkg::rsp_type                 rsp
);

   logic [bmi_pkg::DATA_W-1:0] smask;
   logic [bmi_pkg::DATA_W-1:0] a;
   logic [bmi_pkg::DATA_W-1:0] b;
   logic [7:0]                 size;
   logic [bmi_pkg::DATA_W-1:0] a_dec;
   logic [bmi_pkg::DATA_W-1:0] a_neg;
   logic [7:0]                 idx;
   logic [7:0]                 len;
   logic [bmi_pkg::DATA_W-1:0] low_mask_idx;
   logic [bmi_pkg::DATA_W-1:0] low_mask_len;
   logic [bmi_pkg::DATA_W-1:0] a_shr;

   assign smask = wide ? '1 : bmi_pkg::NARROW_MASK;
   assign a     = src_a & smask;
   assign b     = src_b & smask;
   assign size  = wide ? bmi_pkg::SIZE_WIDE : bmi_pkg::SIZE_NARROW;
   assign a_dec = a - 64'd1;
   assign a_neg = '0 - a;
   assign idx   = b[7:0];
   assign len   = b[15:8];

   // masks of the low idx / len bits, valid while the count is below 64
   assign low_mask_idx = ~({bmi_pkg::DATA_W{1'b1}} << idx[5:0]);
   assign low_mask_len = ~({bmi_pkg::DATA_W{1'b1}} << len[5:0]);
   assign a_shr        = a >> idx[5:0];

   always_comb begin
      logic [bmi_pkg::DATA_W-1:0] res;
      logic                       cf;
      logic                       safe_kind;
      logic                       is_bextr;
      logic                       known;

      res       = '0;
      cf        = 1'b0;
      safe_kind = 1'b0;
      is_bextr  = 1'b0;
      known     = 1'b1;

      case (bmi_pkg::func_type'(func))
         bmi_pkg::FUNC_ANDN: begin
            res = a & ~b;
         end
         bmi_pkg::FUNC_BLSR: begin
            res       = a & a_dec;
            cf        = (a == '0);
            safe_kind = 1'b1;
         end
         bmi_pkg::FUNC_BLSMSK: begin
            res       = a ^ a_dec;
            cf        = (a == '0);
            safe_kind = 1'b1;
         end
         bmi_pkg::FUNC_BLSI: begin
            res       = a & a_neg;
            cf        = (a != '0);
            safe_kind = 1'b1;
         end
         bmi_pkg::FUNC_BZHI: begin
            if (idx < size) begin
               res = a & low_mask_idx;
            end else begin
               res = a;
               cf  = 1'b1;
            end
            safe_kind = 1'b1;
         end
         bmi_pkg::FUNC_BEXTR: begin
            is_bextr = 1'b1;
            if ((len != '0) && (idx < size)) begin
               res = (len < size) ? (a_shr & low_mask_len) : a_shr;
            end
         end
         default: begin
            known = 1'b0;
         end
      endcase

      res = res & smask;

      rsp               = '0;
      rsp.result        = res;
      rsp.carry_flag    = cf;
      rsp.zero_flag     = known && (res == '0);
      rsp.sign_flag     = known && !is_bextr && (wide ? res[63] : res[31]);
      rsp.overflow_flag = 1'b0;
      rsp.adjust_flag   = 1'b0;
      rsp.af_pf_written = is_bextr || (safe_kind && cfg.safe_undefined_flags);
      rsp.parity_flag   = safe_kind && cfg.safe_undefined_flags &&
                          !cfg.pf_cleared_mode && !(^res[7:0]);
   end

endmodule

`default_nettype wire

// ===== hdl/bmi_bit_manipulation_alu_unit.sv =====
// top level of the bit manipulation alu: operand register, datapath, result register
// depends on bmi_pkg, bmi_req_if, bmi_rsp_if, bmi_csr, bmi_exec and the assertion header
`default_nettype none
`include "bmi_bit_manipulation_alu_unit_assert.svh"

// Executes one x86 BMI1/BMI2 operation (ANDN, BLSR, BLSMSK, BLSI, BZHI, BEXTR) per
// request on 64-bit or zero-extended 32-bit operands and returns the result with
// CF/ZF/SF/OF/AF/PF and a flag saying whether AF and PF hold defined values. A new
// request is taken every cycle unless the result side stalls; each result passes through
// the operand register and then the result register, and throughput is set only by the
// result side taking responses. Unused op codes return all zeros. The two control
// registers are written through the csr_ port and should only change while no request
// is in flight.

module bmi_bit_manipulation_alu_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   bmi_req_if.sink                                req_if,
   bmi_rsp_if.source                              rsp_if,
   input  wire logic                              csr_we,
   input  wire logic [bmi_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [bmi_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // configuration
   bmi_pkg::cfg_type cfg;

   // operand stage
   logic                        op_valid_ff;
   logic                        op_valid_in;
   logic [bmi_pkg::FUNC_W-1:0]  op_func_ff;
   logic                        op_wide_ff;
   logic [bmi_pkg::DATA_W-1:0]  op_src_a_ff;
   logic [bmi_pkg::DATA_W-1:0]  op_src_b_ff;

   // result stage
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   bmi_pkg::rsp_type            rsp_ff;
   bmi_pkg::rsp_type            rsp_in;

   logic                        req_take;
   logic                        rsp_load;
   logic                        op_free;

   bmi_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bmi_exec u_exec (
      .func  (op_func_ff),
      .wide  (op_wide_ff),
      .src_a (op_src_a_ff),
      .src_b (op_src_b_ff),
      .cfg   (cfg),
      .rsp   (rsp_in)
   );

   // result register loads a pending operand when empty or when its content is being taken
   assign rsp_load = op_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   // operand register is free when empty or moving on this cycle
   assign op_free  = !op_valid_ff || rsp_load;
   assign req_take = req_if.valid && op_free;

   assign req_if.ready = op_free;

   always_comb begin
      op_valid_in = op_valid_ff;
      if (req_take) begin
         op_valid_in = 1'b1;
      end else if (rsp_load) begin
         op_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         op_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         op_valid_ff  <= op_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_func_ff  <= req_if.func;
         op_wide_ff  <= req_if.wide;
         op_src_a_ff <= req_if.src_a;
         op_src_b_ff <= req_if.src_b;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.result        = rsp_ff.result;
   assign rsp_if.carry_flag    = rsp_ff.carry_flag;
   assign rsp_if.zero_flag     = rsp_ff.zero_flag;
   assign rsp_if.sign_flag     = rsp_ff.sign_flag;
   assign rsp_if.overflow_flag = rsp_ff.overflow_flag;
   assign rsp_if.adjust_flag   = rsp_ff.adjust_flag;
   assign rsp_if.parity_flag   = rsp_ff.parity_flag;
   assign rsp_if.af_pf_written = rsp_ff.af_pf_written;

   // a pending operand moves into a free result register and shows up next cycle
   `BMI_ASSERT_CLK(a_op_reaches_rsp, clock, reset, rsp_load |=> rsp_valid_ff, "operand lost")
   // a held request is never overwritten while the result side stalls
   `BMI_ASSERT_CLK(a_no_overwrite, clock, reset, (op_valid_ff && !rsp_load) |-> !req_if.ready, "operand overwritten")
   // parity only meaningful when af/pf are reported as written
   `BMI_ASSERT_CLK(a_pf_needs_written, clock, reset, (rsp_valid_ff && !rsp_ff.af_pf_written) |-> !rsp_ff.parity_flag, "parity while unwritten")
   // both stages come out of reset empty
   `BMI_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> (!op_valid_ff && !rsp_valid_ff), "pipeline not empty after reset")

endmodule

`default_nettype wire

// ===== tb/tb_bmi_bit_manipulation_alu_unit.sv =====
// self-checking testbench for the bit manipulation alu: a directed table, then random
// requests over several flag settings, each response checked against the table or a local predictor
// depends on bmi_pkg, bmi_req_if, bmi_rsp_if and bmi_bit_manipulation_alu_unit
`timescale 1ns / 1ps

module tb_bmi_bit_manipulation_alu_unit;

   // op codes the block treats as no-ops; they must come back as all zeros
   localparam logic [bmi_pkg::FUNC_W-1:0] FUNC_UNUSED_A = 3'd6;
   localparam logic [bmi_pkg::FUNC_W-1:0] FUNC_UNUSED_B = 3'd7;

   localparam logic [bmi_pkg::DATA_W-1:0] ALL_ONES = '1;

   localparam int RESET_CYCLES     = 7;
   localparam int PIPE_SETTLE      = 4;    // two-stage pipe plus margin
   localparam int LONG_HOLD_CYCLES = 40;
   localparam int N_PHASES         = 6;
   localparam int ITEMS_PER_PHASE  = 215;
   localparam int N_DIRECTED       = 24;

   // one row of the directed table; want is only used where has_want is set
   typedef struct packed {
      logic [bmi_pkg::FUNC_W-1:0] func;
      logic                       wide;
      logic [bmi_pkg::DATA_W-1:0] src_a;
      logic [bmi_pkg::DATA_W-1:0] src_b;
      logic                       has_want;
      bmi_pkg::rsp_type           want;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            csr_we;
   logic [bmi_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [bmi_pkg::CSR_DATA_W-1:0]  csr_wdata;

   bmi_req_if req_bus ();
   bmi_rsp_if rsp_bus ();

   bmi_bit_manipulation_alu_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // results still owed by the block, oldest first
   bmi_pkg::rsp_type expected_results [$];
   // flag settings as the block should hold them
   bmi_pkg::cfg_type flag_settings;
   int unsigned      fail_count;
   int unsigned      sender_idle_pct;
   int unsigned      receiver_idle_pct;
   bit               long_hold_req;

   // one setting per random phase; both extremes of each register come up
   bmi_pkg::cfg_type phase_settings [N_PHASES] =
      '{2'b10, 2'b11, 2'b01, 2'b00, 2'b11, 2'b10};

   // expected words: {result, cf zf sf of af pf written}
   directed_row_type directed_rows [N_DIRECTED] = '{
      '{bmi_pkg::FUNC_ANDN,   1'b1, ALL_ONES, 64'h0,    1'b1, {ALL_ONES, 7'b0010000}},
      '{bmi_pkg::FUNC_ANDN,   1'b1, ALL_ONES, ALL_ONES, 1'b1, {64'h0, 7'b0100000}},
      '{bmi_pkg::FUNC_ANDN,   1'b0, ALL_ONES, 64'h0,    1'b1, {64'hFFFF_FFFF, 7'b0010000}},
      '{bmi_pkg::FUNC_BLSR,   1'b1, 64'h0,    ALL_ONES, 1'b1, {64'h0, 7'b1100000}},
      '{bmi_pkg::FUNC_BLSR,   1'b1, 64'h8000_0000_0000_0000, 64'h0, 1'b1,
        {64'h0, 7'b0100000}},
      '{bmi_pkg::FUNC_BLSMSK, 1'b1, 64'h0,    64'h0,    1'b1, {ALL_ONES, 7'b1010000}},
      '{bmi_pkg::FUNC_BLSMSK, 1'b0, 64'hFFFF_FFFF_0000_0000, 64'h0, 1'b1,
        {64'hFFFF_FFFF, 7'b1010000}},
      '{bmi_pkg::FUNC_BLSI,   1'b1, ALL_ONES, 64'h0,    1'b1, {64'h1, 7'b1000000}},
      '{bmi_pkg::FUNC_BLSI,   1'b1, 64'h0,    64'h0,    1'b1, {64'h0, 7'b0100000}},
      '{bmi_pkg::FUNC_BZHI,   1'b1, ALL_ONES, 64'h0,    1'b1, {64'h0, 7'b0100000}},
      '{bmi_pkg::FUNC_BZHI,   1'b1, ALL_ONES, 64'h40,   1'b1, {ALL_ONES, 7'b1010000}},
      '{bmi_pkg::FUNC_BZHI,   1'b1, ALL_ONES, 64'd63,   1'b0, '0},
      '{bmi_pkg::FUNC_BZHI,   1'b0, ALL_ONES, 64'hFF,   1'b1, {64'hFFFF_FFFF, 7'b1010000}},
      '{bmi_pkg::FUNC_BZHI,   1'b0, ALL_ONES, 64'd31,   1'b0, '0},
      '{bmi_pkg::FUNC_BEXTR,  1'b1, ALL_ONES, 64'h0,    1'b1, {64'h0, 7'b0100001}},
      '{bmi_pkg::FUNC_BEXTR,  1'b1, ALL_ONES, 64'h0840, 1'b1, {64'h0, 7'b0100001}},
      '{bmi_pkg::FUNC_BEXTR,  1'b1, ALL_ONES, 64'hFF00, 1'b1, {ALL_ONES, 7'b0000001}},
      '{bmi_pkg::FUNC_BEXTR,  1'b0, 64'h1234_5678_9ABC_DEF0, 64'h0804, 1'b0, '0},
      '{bmi_pkg::FUNC_BEXTR,  1'b1, 64'h8000_0000_0000_0000, 64'h013F, 1'b1,
        {64'h1, 7'b0000001}},
      '{FUNC_UNUSED_A,        1'b1, ALL_ONES, ALL_ONES, 1'b1, '0},
      '{FUNC_UNUSED_B,        1'b0, ALL_ONES, ALL_ONES, 1'b1, '0},
      '{bmi_pkg::FUNC_ANDN,   1'b0, 64'hFFFF_FFFF_1234_5678, 64'hFFFF_FFFF_0000_FFFF,
        1'b0, '0},
      '{bmi_pkg::FUNC_BLSR,   1'b1, 64'h0000_0000_0000_0F00, 64'h0, 1'b0, '0},
      '{bmi_pkg::FUNC_BZHI,   1'b1, 64'hDEAD_BEEF_CAFE_F00D, 64'hFFFF_FFFF_FFFF_FF10,
        1'b0, '0}
   };

   // result and flags of one bmi operation under the given flag settings
   function automatic bmi_pkg::rsp_type bmi_result(
         input logic [bmi_pkg::FUNC_W-1:0] func, input logic wide,
         input logic [bmi_pkg::DATA_W-1:0] src_a,
         input logic [bmi_pkg::DATA_W-1:0] src_b,
         input bmi_pkg::cfg_type settings);
      logic [bmi_pkg::DATA_W-1:0] size_mask, a, b, res;
      logic [7:0]                 size, bit_index, field_len;
      logic                       cf, af_pf_kind;
      bmi_pkg::rsp_type           r;
      size_mask  = wide ? ALL_ONES : bmi_pkg::NARROW_MASK;
      size       = wide ? bmi_pkg::SIZE_WIDE : bmi_pkg::SIZE_NARROW;
      a          = src_a & size_mask;
      b          = src_b & size_mask;
      res        = '0;
      cf         = 1'b0;
      af_pf_kind = 1'b0;
      r          = '0;
      case (func)
         bmi_pkg::FUNC_ANDN: res = a & ~b;
         bmi_pkg::FUNC_BLSR: begin
            res        = a & (a - 64'd1);
            cf         = (a == '0);
            af_pf_kind = 1'b1;
         end
         bmi_pkg::FUNC_BLSMSK: begin
            res        = a ^ (a - 64'd1);
            cf         = (a == '0);
            af_pf_kind = 1'b1;
         end
         bmi_pkg::FUNC_BLSI: begin
            res        = a & (64'd0 - a);
            cf         = (a != '0);
            af_pf_kind = 1'b1;
         end
         bmi_pkg::FUNC_BZHI: begin
            bit_index  = b[7:0];
            af_pf_kind = 1'b1;
            if (bit_index < size) begin
               res = a & ((64'd1 << bit_index) - 64'd1);
            end else begin
               res = a;
               cf  = 1'b1;
            end
         end
         bmi_pkg::FUNC_BEXTR: begin
            bit_index       = b[7:0];
            field_len       = b[15:8];
            r.af_pf_written = 1'b1;
            if (field_len != 8'd0 && bit_index < size) begin
               res = a >> bit_index;
               if (field_len < size) begin
                  res &= (64'd1 << field_len) - 64'd1;
               end
            end
         end
         default: return '0;
      endcase
      res &= size_mask;
      r.result     = res;
      r.carry_flag = cf;
      r.zero_flag  = (res == '0);
      r.sign_flag  = (func == bmi_pkg::FUNC_BEXTR) ? 1'b0 :
                     (wide ? res[bmi_pkg::DATA_W-1] : res[bmi_pkg::SIZE_NARROW-1]);
      // bextr aside, af/pf are defined only in safe mode; pf is low-byte even parity, 0 if cleared
      if (af_pf_kind && settings.safe_undefined_flags) begin
         r.af_pf_written = 1'b1;
         r.parity_flag   = settings.pf_cleared_mode ? 1'b0 : ~^res[7:0];
      end
      return r;
   endfunction

   // operands with plenty of edge patterns: zero, all ones, single bits, half-words
   function automatic logic [bmi_pkg::DATA_W-1:0] pick_operand();
      case ($urandom_range(7, 0))
         0:       return '0;
         1:       return ALL_ONES;
         2:       return 64'd1 << $urandom_range(63, 0);
         3:       return ~(64'd1 << $urandom_range(63, 0));
         4:       return {32'h0, $urandom};
         5:       return {$urandom, 32'h0};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // bit index or length byte, weighted towards the operand size boundaries
   function automatic logic [7:0] pick_bit_index();
      case ($urandom_range(3, 0))
         0:       return 8'($urandom_range(255, 0));
         1:       return 8'($urandom_range(70, 0));
         2:       return bmi_pkg::SIZE_NARROW - 8'd2 + 8'($urandom_range(4, 0));
         default: return bmi_pkg::SIZE_WIDE - 8'd2 + 8'($urandom_range(4, 0));
      endcase
   endfunction

   // a one-bit flag zero-extended for the mismatch report
   function automatic logic [bmi_pkg::DATA_W-1:0] flag_word(input logic f);
      return {{(bmi_pkg::DATA_W-1){1'b0}}, f};
   endfunction

   // offer one request, idling first at random; called and returns at a falling edge
   task automatic offer_request(input logic [bmi_pkg::FUNC_W-1:0] func, input logic wide,
                                input logic [bmi_pkg::DATA_W-1:0] src_a,
                                input logic [bmi_pkg::DATA_W-1:0] src_b,
                                input bmi_pkg::rsp_type want);
      while ($urandom_range(99, 0) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.func  <= func;
      req_bus.wide  <= wide;
      req_bus.src_a <= src_a;
      req_bus.src_b <= src_b;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      expected_results.push_back(want);
      @(negedge clock);
   endtask

   // stop sending and let every owed result come back, then give the pipe time to empty
   task automatic drain_requests();
      req_bus.valid <= 1'b0;
      while (expected_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (PIPE_SETTLE) @(negedge clock);
   endtask

   task automatic report_mismatch(input string field,
                                  input logic [bmi_pkg::DATA_W-1:0] want,
                                  input logic [bmi_pkg::DATA_W-1:0] got);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
      end
   endtask

   // stimulus: reset, directed table, then random phases with flag writes in between
   initial begin : request_source
      logic [bmi_pkg::FUNC_W-1:0] func;
      logic                       wide;
      logic [bmi_pkg::DATA_W-1:0] src_a, src_b;
      bmi_pkg::rsp_type           want;
      req_bus.valid     = 1'b0;
      req_bus.func      = '0;
      req_bus.wide      = 1'b0;
      req_bus.src_a     = '0;
      req_bus.src_b     = '0;
      csr_we            = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      flag_settings     = '0;
      fail_count        = 0;
      long_hold_req     = 1'b0;
      sender_idle_pct   = 16;
      receiver_idle_pct = 59;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table at the reset flag settings
      for (int i = 0; i < N_DIRECTED; i++) begin
         want = directed_rows[i].has_want ? directed_rows[i].want
                : bmi_result(directed_rows[i].func, directed_rows[i].wide,
                             directed_rows[i].src_a, directed_rows[i].src_b, flag_settings);
         offer_request(directed_rows[i].func, directed_rows[i].wide, directed_rows[i].src_a,
                       directed_rows[i].src_b, want);
      end

      for (int phase = 0; phase < N_PHASES; phase++) begin
         // flags only change with nothing in flight
         drain_requests();
         csr_we    <= 1'b1;
         csr_index <= bmi_pkg::CSR_SAFE_FLAGS;
         csr_wdata <= phase_settings[phase].safe_undefined_flags;
         @(negedge clock);
         csr_index <= bmi_pkg::CSR_PF_CLEARED;
         csr_wdata <= phase_settings[phase].pf_cleared_mode;
         @(negedge clock);
         csr_we        <= 1'b0;
         flag_settings  = phase_settings[phase];

         // receiver slow with a busy sender, then sender sparse with a quick receiver, then flat out
         case (phase / 2)
            0: begin
               sender_idle_pct   = 16;
               receiver_idle_pct = 59;
            end
            1: begin
               sender_idle_pct   = 59;
               receiver_idle_pct = 16;
            end
            default: begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
            end
         endcase

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // one long receiver stall so the pipe backs up into the request side
            if (phase == 0 && n == 40) long_hold_req = 1'b1;
            if ($urandom_range(15, 0) == 0) begin
               func = $urandom_range(1, 0) ? FUNC_UNUSED_A : FUNC_UNUSED_B;
            end else begin
               func = 3'($urandom_range(5, 0));
            end
            wide  = 1'($urandom_range(1, 0));
            src_a = pick_operand();
            src_b = {$urandom, $urandom};
            case (func)
               bmi_pkg::FUNC_ANDN:  src_b = pick_operand();
               bmi_pkg::FUNC_BZHI:  src_b[7:0] = pick_bit_index();
               bmi_pkg::FUNC_BEXTR: begin
                  src_b[7:0]  = pick_bit_index();
                  src_b[15:8] = pick_bit_index();
               end
               default: ;
            endcase
            offer_request(func, wide, src_a, src_b,
                          bmi_result(func, wide, src_a, src_b, flag_settings));
         end
      end

      drain_requests();
      repeat (PIPE_SETTLE) @(negedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // response ready: random idling, plus the long hold counted here
   initial begin : response_sink
      int unsigned hold_left;
      hold_left     = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = LONG_HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99, 0) >= receiver_idle_pct);
         end
      end
   end

   // every accepted response against the oldest owed result
   always @(posedge clock) begin
      bmi_pkg::rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_results.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) begin
               $display("%0t: response with no request outstanding, result %h",
                        $time, rsp_bus.result);
            end
         end else begin
            want = expected_results.pop_front();
            if (rsp_bus.result !== want.result)
               report_mismatch("result", want.result, rsp_bus.result);
            if (rsp_bus.carry_flag !== want.carry_flag)
               report_mismatch("carry_flag", flag_word(want.carry_flag),
                               flag_word(rsp_bus.carry_flag));
            if (rsp_bus.zero_flag !== want.zero_flag)
               report_mismatch("zero_flag", flag_word(want.zero_flag),
                               flag_word(rsp_bus.zero_flag));
            if (rsp_bus.sign_flag !== want.sign_flag)
               report_mismatch("sign_flag", flag_word(want.sign_flag),
                               flag_word(rsp_bus.sign_flag));
            if (rsp_bus.overflow_flag !== want.overflow_flag)
               report_mismatch("overflow_flag", flag_word(want.overflow_flag),
                               flag_word(rsp_bus.overflow_flag));
            if (rsp_bus.adjust_flag !== want.adjust_flag)
               report_mismatch("adjust_flag", flag_word(want.adjust_flag),
                               flag_word(rsp_bus.adjust_flag));
            if (rsp_bus.parity_flag !== want.parity_flag)
               report_mismatch("parity_flag", flag_word(want.parity_flag),
                               flag_word(rsp_bus.parity_flag));
            if (rsp_bus.af_pf_written !== want.af_pf_written)
               report_mismatch("af_pf_written", flag_word(want.af_pf_written),
                               flag_word(rsp_bus.af_pf_written));
         end
      end
   end

   // watchdog, far beyond the slowest correct run
   initial begin : watchdog
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
